[design/image_convolution_3x3_assert.svh]
// Assertion macros for the 3x3 convolution block.
// Included by the top level; relies on nothing else.
`ifndef IMAGE_CONVOLUTION_3X3_ASSERT_SVH
`define IMAGE_CONVOLUTION_3X3_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define ICV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("icv assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ICV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("icv assertion failed");

`endif

[design/icv_pkg.sv]
// Shared types and constants for the 3x3 convolution block.
// No dependencies.
`timescale 1ns / 1ps

package icv_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIDE_W     = 12;
    localparam int KROW_W     = 24;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int DOT_W      = PROD_W + 1;
    localparam int SUM_W      = DOT_W + 2;
    localparam int VAL_W      = 16;
    localparam int OUT_POS_W  = 11;
    localparam int CFG_IDX_W  = 3;

    localparam logic [SIDE_W-1:0] MIN_SIDE    = SIDE_W'(3);
    localparam logic [SIDE_W-1:0] MAX_W_SIDE  = SIDE_W'(MAX_WIDTH);
    localparam logic [SIDE_W-1:0] MAX_H_SIDE  = SIDE_W'(MAX_HEIGHT);

    localparam logic [KROW_W-1:0] KTOP_RESET  = KROW_W'(24'h010101);
    localparam logic [KROW_W-1:0] KMID_RESET  = KROW_W'(24'h01F801);
    localparam logic [KROW_W-1:0] KBOT_RESET  = KROW_W'(24'h010101);
    localparam logic [SIDE_W-1:0] WIDTH_RESET = SIDE_W'(640);
    localparam logic [SIDE_W-1:0] HEIGHT_RESET = SIDE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MID    = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        logic signed [COEF_W-1:0] top;
        logic signed [COEF_W-1:0] mid;
        logic signed [COEF_W-1:0] bot;
    } t_kcol;

    typedef struct packed {
        logic                 emit;
        logic                 border;
        logic                 done;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [OUT_POS_W-1:0]    row;
        logic [OUT_POS_W-1:0]    col;
        logic                    done;
    } t_res;

endpackage

[design/icv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module icv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/icv_cell.sv]
// One window column: holds three pixels, shifts to its neighbor and
// forms the registered dot product with one kernel column. Uses icv_pkg.
`timescale 1ns / 1ps

module icv_cell
    import icv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic                    i_advance,
    input  t_col                    i_col,
    input  t_kcol                   i_coef,
    output t_col                    o_col,
    output logic signed [DOT_W-1:0] o_dot
);

    t_col                     r_col;
    logic signed [DOT_W-1:0]  r_dot;
    logic signed [DOT_W-1:0]  n_dot;
    logic signed [PROD_W-1:0] w_prod_top;
    logic signed [PROD_W-1:0] w_prod_mid;
    logic signed [PROD_W-1:0] w_prod_bot;

    always_comb begin
        w_prod_top = i_coef.top * $signed({1'b0, r_col.top});
        w_prod_mid = i_coef.mid * $signed({1'b0, r_col.mid});
        w_prod_bot = i_coef.bot * $signed({1'b0, r_col.bot});
        n_dot = DOT_W'(w_prod_top) + DOT_W'(w_prod_mid) + DOT_W'(w_prod_bot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_dot <= n_dot;
        end
    end

    assign o_col = r_col;
    assign o_dot = r_dot;

endmodule

[design/image_convolution_3x3.sv]
// 3x3 convolution over a raster pixel stream, saturated to signed 16 bits.
// Throughput: one pixel per cycle while the skid register is free, set by the
// line-store RAM read register and the per-column multiply register in the
// chain of window cells.
// Reset (synchronous, active low) restores the registers, position and window;
// the line stores are not cleared. Uses icv_pkg, icv_ram and icv_cell.
`timescale 1ns / 1ps

module image_convolution_3x3
    import icv_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [KROW_W-1:0]           i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [PIX_W-1:0]            i_pixel,
    input  logic                        i_frame_start,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [VAL_W-1:0]     o_filtered_value,
    output logic [OUT_POS_W-1:0]        o_out_row,
    output logic [OUT_POS_W-1:0]        o_out_col,
    output logic                        o_frame_done
);

    `include "image_convolution_3x3_assert.svh"

    logic [KROW_W-1:0] r_ktop;
    logic [KROW_W-1:0] r_kmid;
    logic [KROW_W-1:0] r_kbot;
    logic [SIDE_W-1:0] r_width;
    logic [SIDE_W-1:0] r_height;

    logic [COL_W-1:0]  r_col_cnt;
    logic [ROW_W-1:0]  r_row_cnt;

    logic              w_adv;
    logic              w_accept;
    logic [SIDE_W-1:0] w_w;
    logic [SIDE_W-1:0] w_h;
    logic [SIDE_W-1:0] w_r0;
    logic [SIDE_W-1:0] w_c0;
    logic [SIDE_W-1:0] w_r1;
    logic [SIDE_W-1:0] w_c1;
    t_tag              w_tag0;

    logic              r_s1_valid;
    t_tag              r_s1_tag;
    logic [COL_W-1:0]  r_s1_addr;
    t_pix              r_s1_pix;
    logic              r_byp;
    t_pix              r_byp_u;
    t_pix              r_byp_m;
    t_pix              w_rd_u;
    t_pix              w_rd_m;
    t_pix              w_u;
    t_pix              w_m;
    logic              w_s1_fire;
    t_col              w_new_col;

    logic              r_s2_valid;
    t_tag              r_s2_tag;
    logic              r_s3_valid;
    t_tag              r_s3_tag;

    t_col              w_col0;
    t_col              w_col1;
    t_col              w_col2;
    t_kcol             w_kcol [3];
    logic signed [DOT_W-1:0] w_dot [3];

    logic signed [SUM_W-1:0] w_sum;
    t_res              w_res;
    logic              w_push;

    logic              r_out_valid;
    logic              r_skid_valid;
    t_res              r_out;
    t_res              r_skid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktop   <= KTOP_RESET;
            r_kmid   <= KMID_RESET;
            r_kbot   <= KBOT_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL_TOP:    r_ktop   <= i_cfg_wdata;
                CFG_KERNEL_MID:    r_kmid   <= i_cfg_wdata;
                CFG_KERNEL_BOTTOM: r_kbot   <= i_cfg_wdata;
                CFG_IMAGE_WIDTH:   r_width  <= i_cfg_wdata[SIDE_W-1:0];
                CFG_IMAGE_HEIGHT:  r_height <= i_cfg_wdata[SIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the skid register is free.
    assign w_adv      = !r_skid_valid;
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    // Position of the arriving pixel and of the one after it.
    always_comb begin
        w_w = (r_width < MIN_SIDE) ? MIN_SIDE :
              ((r_width > MAX_W_SIDE) ? MAX_W_SIDE : r_width);
        w_h = (r_height < MIN_SIDE) ? MIN_SIDE :
              ((r_height > MAX_H_SIDE) ? MAX_H_SIDE : r_height);
        if (i_frame_start) begin
            w_r0 = '0;
            w_c0 = '0;
        end else begin
            w_r0 = SIDE_W'(r_row_cnt);
            w_c0 = SIDE_W'(r_col_cnt);
            if (w_c0 >= w_w) begin
                w_c0 = '0;
                w_r0 = w_r0 + SIDE_W'(1);
            end
            if (w_r0 >= w_h) begin
                w_r0 = '0;
            end
        end
        w_c1 = w_c0 + SIDE_W'(1);
        w_r1 = w_r0;
        if (w_c1 >= w_w) begin
            w_c1 = '0;
            w_r1 = w_r0 + SIDE_W'(1);
            if (w_r1 >= w_h) begin
                w_r1 = '0;
            end
        end
        w_tag0.emit   = (w_r0 != '0) && (w_c0 != '0);
        w_tag0.border = (w_r0 == SIDE_W'(1)) || (w_c0 == SIDE_W'(1));
        w_tag0.done   = (w_r0 == w_h - SIDE_W'(1)) && (w_c0 == w_w - SIDE_W'(1));
        w_tag0.row    = OUT_POS_W'(w_r0 - SIDE_W'(1));
        w_tag0.col    = OUT_POS_W'(w_c0 - SIDE_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_accept) begin
            r_col_cnt <= COL_W'(w_c1);
            r_row_cnt <= ROW_W'(w_r1);
        end
    end

    // Line stores: read when the pixel enters, written when it leaves stage 1.
    assign w_s1_fire = w_adv && r_s1_valid;

    icv_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_store_upper (
        .i_clk  (i_clk),
        .i_we   (w_s1_fire),
        .i_waddr(r_s1_addr),
        .i_wdata(w_m),
        .i_re   (w_adv),
        .i_raddr(COL_W'(w_c0)),
        .o_rdata(w_rd_u)
    );

    icv_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_store_lower (
        .i_clk  (i_clk),
        .i_we   (w_s1_fire),
        .i_waddr(r_s1_addr),
        .i_wdata(r_s1_pix),
        .i_re   (w_adv),
        .i_raddr(COL_W'(w_c0)),
        .o_rdata(w_rd_m)
    );

    // A read of the address being written in the same cycle takes the new data.
    assign w_u = r_byp ? r_byp_u : w_rd_u;
    assign w_m = r_byp ? r_byp_m : w_rd_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_byp      <= w_s1_fire && (r_s1_addr == COL_W'(w_c0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_tag  <= w_tag0;
            r_s1_addr <= COL_W'(w_c0);
            r_s1_pix  <= i_pixel;
            r_byp_u   <= w_m;
            r_byp_m   <= r_s1_pix;
            r_s2_tag  <= r_s1_tag;
            r_s3_tag  <= r_s2_tag;
        end
    end

    // Chain of window cells, newest column on the right.
    assign w_new_col = '{top: w_u, mid: w_m, bot: r_s1_pix};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_kcol[k].top = $signed(r_ktop[COEF_W*k +: COEF_W]);
            w_kcol[k].mid = $signed(r_kmid[COEF_W*k +: COEF_W]);
            w_kcol[k].bot = $signed(r_kbot[COEF_W*k +: COEF_W]);
        end
    end

    icv_cell u_cell2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_s1_fire),
        .i_advance(w_adv),
        .i_col    (w_new_col),
        .i_coef   (w_kcol[2]),
        .o_col    (w_col2),
        .o_dot    (w_dot[2])
    );

    icv_cell u_cell1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_s1_fire),
        .i_advance(w_adv),
        .i_col    (w_col2),
        .i_coef   (w_kcol[1]),
        .o_col    (w_col1),
        .o_dot    (w_dot[1])
    );

    icv_cell u_cell0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_s1_fire),
        .i_advance(w_adv),
        .i_col    (w_col1),
        .i_coef   (w_kcol[0]),
        .o_col    (w_col0),
        .o_dot    (w_dot[0])
    );

    // Final sum, saturation and border zeroing.
    always_comb begin
        w_sum = SUM_W'(w_dot[0]) + SUM_W'(w_dot[1]) + SUM_W'(w_dot[2]);
        if (r_s3_tag.border) begin
            w_res.value = '0;
        end else if (w_sum > SUM_W'(32767)) begin
            w_res.value = 16'sh7FFF;
        end else if (w_sum < -SUM_W'(32768)) begin
            w_res.value = 16'sh8000;
        end else begin
            w_res.value = VAL_W'(w_sum);
        end
        w_res.row  = r_s3_tag.row;
        w_res.col  = r_s3_tag.col;
        w_res.done = r_s3_tag.done;
    end

    assign w_push = w_adv && r_s3_valid && r_s3_tag.emit;

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid  <= r_skid_valid || w_push;
            r_skid_valid <= 1'b0;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out.value;
    assign o_out_row        = r_out.row;
    assign o_out_col        = r_out.col;
    assign o_frame_done     = r_out.done;

    `ICV_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ICV_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        r_out_valid && !i_out_ready && w_push, r_skid_valid)
    `ICV_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n,
        r_skid_valid && i_out_ready, r_out_valid && !r_skid_valid)

endmodule

[dv/tb_image_convolution_3x3.sv]
// Self-checking testbench for image_convolution_3x3: a scoreboard class predicts each
// filtered result from the accepted pixels and checks the block's output stream.
// Depends on icv_pkg and the image_convolution_3x3 top level.
`timescale 1ns / 1ps

module tb_image_convolution_3x3;
    import icv_pkg::*;

    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES = 10;
    localparam time TIMEOUT_NS = 5_000_000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    class conv_scoreboard;
        logic [KROW_W-1:0] k_top;
        logic [KROW_W-1:0] k_mid;
        logic [KROW_W-1:0] k_bot;
        logic [SIDE_W-1:0] width_reg;
        logic [SIDE_W-1:0] height_reg;
        t_pix              upper_line [MAX_WIDTH];
        t_pix              lower_line [MAX_WIDTH];
        t_pix              win [6];
        int                col_pos;
        int                row_pos;
        t_res              filtered_due [$];
        int                mismatches;

        function new();
            k_top = KTOP_RESET;
            k_mid = KMID_RESET;
            k_bot = KBOT_RESET;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (lower_line[i]) lower_line[i] = '0;
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            mismatches = 0;
        endfunction

        function int clamp_side(int v, int hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        function int coef(logic [KROW_W-1:0] krow, int pos);
            return int'($signed(krow[8*pos +: 8]));
        endfunction

        function void set_reg(t_cfg_idx idx, logic [KROW_W-1:0] val);
            case (idx)
                CFG_KERNEL_TOP:    k_top = val;
                CFG_KERNEL_MID:    k_mid = val;
                CFG_KERNEL_BOTTOM: k_bot = val;
                CFG_IMAGE_WIDTH:   width_reg = val[SIDE_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg = val[SIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pix p, logic fs);
            int   w;
            int   h;
            int   r;
            int   c;
            int   s;
            t_pix u;
            t_pix m;
            t_res res;
            w = clamp_side(int'(width_reg), MAX_WIDTH);
            h = clamp_side(int'(height_reg), MAX_HEIGHT);
            if (fs) begin
                r = 0;
                c = 0;
            end else begin
                r = row_pos;
                c = col_pos;
                if (c >= w) begin
                    c = 0;
                    r++;
                end
                if (r >= h) r = 0;
            end
            u = upper_line[c];
            m = lower_line[c];
            if (r >= 1 && c >= 1) begin
                s = 0;
                if (r - 1 != 0 && c - 1 != 0 && r - 1 != h - 1 && c - 1 != w - 1) begin
                    s = coef(k_top, 0) * int'(win[0]) + coef(k_top, 1) * int'(win[1])
                      + coef(k_top, 2) * int'(u)
                      + coef(k_mid, 0) * int'(win[2]) + coef(k_mid, 1) * int'(win[3])
                      + coef(k_mid, 2) * int'(m)
                      + coef(k_bot, 0) * int'(win[4]) + coef(k_bot, 1) * int'(win[5])
                      + coef(k_bot, 2) * int'(p);
                    if (s > 32767) s = 32767;
                    if (s < -32768) s = -32768;
                end
                res.value = VAL_W'(s);
                res.row = OUT_POS_W'(r - 1);
                res.col = OUT_POS_W'(c - 1);
                res.done = (r == h - 1 && c == w - 1);
                filtered_due.push_back(res);
            end
            upper_line[c] = m;
            lower_line[c] = p;
            win[0] = win[1];
            win[1] = u;
            win[2] = win[3];
            win[3] = m;
            win[4] = win[5];
            win[5] = p;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endfunction

        function void check_result(logic signed [VAL_W-1:0] value,
                                   logic [OUT_POS_W-1:0] row,
                                   logic [OUT_POS_W-1:0] col,
                                   logic done);
            t_res want;
            if (filtered_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d row %0d col %0d",
                                          value, row, col));
                return;
            end
            want = filtered_due.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %0d, want %0d at row %0d col %0d",
                                          value, want.value, want.row, want.col));
            if (row !== want.row)
                report_mismatch($sformatf("row %0d, want %0d", row, want.row));
            if (col !== want.col)
                report_mismatch($sformatf("col %0d, want %0d", col, want.col));
            if (done !== want.done)
                report_mismatch($sformatf("frame_done %0b, want %0b at row %0d col %0d",
                                          done, want.done, want.row, want.col));
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [KROW_W-1:0]       i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [PIX_W-1:0]        i_pixel;
    logic                    i_frame_start;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [VAL_W-1:0] o_filtered_value;
    logic [OUT_POS_W-1:0]    o_out_row;
    logic [OUT_POS_W-1:0]    o_out_col;
    logic                    o_frame_done;

    conv_scoreboard sb = new();
    int             src_idle_pct = 0;
    int             snk_stall_pct = 0;
    bit             hold_request = 1'b0;

    image_convolution_3x3 uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel          (i_pixel),
        .i_frame_start    (i_frame_start),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_value (o_filtered_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_frame_done     (o_frame_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("image_convolution_3x3 test failed");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready = ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_filtered_value, o_out_row, o_out_col, o_frame_done);
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            IDLE_SEND: begin
                src_idle_pct = 54;
                snk_stall_pct = 0;
            end
            IDLE_RECV: begin
                src_idle_pct = 0;
                snk_stall_pct = 54;
            end
            default: begin
                src_idle_pct = 18;
                snk_stall_pct = 18;
            end
        endcase
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [KROW_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [KROW_W-1:0] kt, input logic [KROW_W-1:0] km,
                             input logic [KROW_W-1:0] kb, input int w, input int h);
        write_reg(CFG_KERNEL_TOP, kt);
        write_reg(CFG_KERNEL_MID, km);
        write_reg(CFG_KERNEL_BOTTOM, kb);
        write_reg(CFG_IMAGE_WIDTH, KROW_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, KROW_W'(h));
    endtask

    task automatic drive_pixel(input t_pix p, input logic fs);
        bit accepted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel = p;
        i_frame_start = fs;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = o_in_ready;
        end
        sb.note_pixel(p, fs);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input logic first_fs, input bit noisy);
        t_pix p;
        logic fs;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(7))
                0: p = 8'h00;
                1: p = 8'hFF;
                default: p = t_pix'($urandom_range(255));
            endcase
            if (i == 0)
                fs = first_fs;
            else if (sb.row_pos == 0 && sb.col_pos == 0)
                fs = 1'($urandom_range(1));
            else
                fs = noisy && ($urandom_range(99) < 3);
            drive_pixel(p, fs);
        end
        i_in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [KROW_W-1:0] kt;
        logic [KROW_W-1:0] km;
        logic [KROW_W-1:0] kb;
        int                w;
        int                h;
        logic              first_fs;
        t_pix              p;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_pixel = '0;
        i_frame_start = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset kernel on a 5x4 frame, then a wrap into the next frame without
        // a frame start, and finally a frame start in the middle of a row.
        set_idling(IDLE_NONE);
        write_reg(CFG_IMAGE_WIDTH, KROW_W'(5));
        write_reg(CFG_IMAGE_HEIGHT, KROW_W'(4));
        for (int i = 0; i < 25; i++) begin
            case (i % 4)
                0: p = 8'hFF;
                1: p = 8'h00;
                2: p = t_pix'(i * 11);
                default: p = t_pix'(255 - i * 7);
            endcase
            drive_pixel(p, (i == 0) || (i == 23));
        end
        i_in_valid = 1'b0;
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            set_idling(t_idle_mode'(ph % 4));
            case (ph)
                1: begin
                    kt = 24'h7F7F7F;
                    km = 24'h7F7F7F;
                    kb = 24'h7F7F7F;
                end
                2: begin
                    kt = 24'h808080;
                    km = 24'h808080;
                    kb = 24'h808080;
                end
                3: begin
                    kt = 24'h000000;
                    km = 24'h000000;
                    kb = 24'h000000;
                end
                default: begin
                    kt = KROW_W'($urandom);
                    km = KROW_W'($urandom);
                    kb = KROW_W'($urandom);
                end
            endcase
            if (ph == 6) begin
                w = 3;
                h = 3;
            end else begin
                w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
                h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
            end
            // A wider frame leaves line-store columns unwritten, so it must restart.
            if (sb.clamp_side(w, MAX_WIDTH) > sb.clamp_side(int'(sb.width_reg), MAX_WIDTH))
                first_fs = 1'b1;
            else
                first_fs = 1'($urandom_range(1));
            configure(kt, km, kb, w, h);
            if (ph == 4) hold_request = 1'b1;
            run_phase($urandom_range(85, 115), first_fs, 1'b1);
            wait_idle();
        end

        set_idling(IDLE_BOTH);
        configure(KROW_W'($urandom), KROW_W'($urandom), KROW_W'($urandom), 4095, 0);
        run_phase(150, 1'b1, 1'b0);
        wait_idle();

        set_idling(IDLE_NONE);
        configure(KTOP_RESET, KMID_RESET, KBOT_RESET, 0, 4095);
        run_phase(180, 1'b1, 1'b0);
        wait_idle();

        if (sb.mismatches == 0) begin
            $display("image_convolution_3x3 test passed");
        end else begin
            $display("image_convolution_3x3 test failed");
        end
        $finish;
    end

endmodule
